/* rtl/rectilinear_path_area_assert.svh */
// ----------------------------------------------------------------------------
// Rectilinear path area assertion macros
// Concurrent assertion shorthands used by the block's checker.
// ----------------------------------------------------------------------------
`ifndef RECTILINEAR_PATH_AREA_ASSERT_SVH
`define RECTILINEAR_PATH_AREA_ASSERT_SVH

// antecedent and consequent in the same cycle
`define RPA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rpa check failed");

// consequent in the cycle after the antecedent
`define RPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rpa check failed");

// consequent in the cycle after reset is seen high
`define RPA_ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("rpa check failed after reset");

`endif

/* rtl/rpa_pkg.sv */
// ----------------------------------------------------------------------------
// Rectilinear path area package
// Field widths, direction codes and the job control word shared by the block.
// ----------------------------------------------------------------------------
package rpa_pkg;

   localparam int DIR_W       = 2;
   localparam int LEN_W       = 20;
   localparam int AREA_W      = 63;
   localparam int SUM_W       = 64;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 64;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef enum logic [DIR_W-1:0] {
      DIR_RIGHT = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_UP    = 2'd3
   } dir_type;

   typedef struct packed {
      logic term_en;
      logic close;
      logic coord_ovf;
   } job_ctl_type;

   localparam int JOB_CTL_W = $bits(job_ctl_type);

endpackage

/* rtl/rectilinear_path_area.sv */
// ----------------------------------------------------------------------------
// Rectilinear path area
// Enclosed cell count of a closed rectilinear path given as a stream of moves.
// ----------------------------------------------------------------------------
// One move is taken per clock while the job queue has room. A move marked last
// holds off the input while the front end issues its corner term, the closing
// corner term when the path turns there, and the wrap-around term to the job
// queue one per cycle, for longer while the job queue is full. Each job then
// runs through the back end's product, combine, difference and accumulate
// stages, and the area is then registered in the output register. A four-entry
// job queue lets the front keep accepting moves while a result waits to be
// taken, until four jobs are queued. No clearing pass is needed after reset.
module rectilinear_path_area
   import rpa_pkg::*;
#(
   parameter int COORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data,    // select_pair
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,      // dir_a, meters_a, dir_b, meters_b
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,      // area
   output logic                  rsp_tuser       // overflow
);

   localparam int JOB_W = JOB_CTL_W + 4 * COORD_BITS;

   job_ctl_type             wr_ctl, rd_ctl;
   logic [COORD_BITS-1:0]   wr_ax, wr_ay, wr_bx, wr_by;
   logic [COORD_BITS-1:0]   rd_ax, rd_ay, rd_bx, rd_by;
   logic [JOB_W-1:0]        wr_job, rd_job;
   logic                    job_push, job_full, job_pop, job_valid;
   logic [AREA_W-1:0]       area;

   assign wr_job = {wr_ctl, wr_ax, wr_ay, wr_bx, wr_by};
   assign {rd_ctl, rd_ax, rd_ay, rd_bx, rd_by} = rd_job;

   rpa_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_dir_a    (dir_type'(req_tdata[DIR_W-1:0])),
      .in_meters_a (req_tdata[DIR_W+LEN_W-1:DIR_W]),
      .in_dir_b    (dir_type'(req_tdata[2*DIR_W+LEN_W-1:DIR_W+LEN_W])),
      .in_meters_b (req_tdata[2*DIR_W+2*LEN_W-1:2*DIR_W+LEN_W]),
      .in_last     (req_tlast),
      .job_full    (job_full),
      .job_push    (job_push),
      .job_ctl     (wr_ctl),
      .job_ax      (wr_ax),
      .job_ay      (wr_ay),
      .job_bx      (wr_bx),
      .job_by      (wr_by)
   );

   rpa_queue #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .wr_data (wr_job),
      .full    (job_full),
      .pop     (job_pop),
      .valid   (job_valid),
      .rd_data (rd_job)
   );

   rpa_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (job_valid),
      .job_pop      (job_pop),
      .job_ctl      (rd_ctl),
      .job_ax       (rd_ax),
      .job_ay       (rd_ay),
      .job_bx       (rd_bx),
      .job_by       (rd_by),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_area     (area),
      .out_overflow (rsp_tuser)
   );

   assign rsp_tdata = {{(RSP_DATA_W-AREA_W){1'b0}}, area};

endmodule

/* rtl/rpa_queue.sv */
// ----------------------------------------------------------------------------
// Rectilinear path area job queue
// Small register FIFO between the move front end and the cross product back end.
// ----------------------------------------------------------------------------
module rpa_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   function automatic logic [AW-1:0] next_ptr(logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
   endfunction

   assign full    = (count_ff == CW'(DEPTH));
   assign valid   = (count_ff != '0);
   assign rd_data = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = CW'(count_ff + CW'(do_push) - CW'(do_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* rtl/rpa_front.sv */
// ----------------------------------------------------------------------------
// Rectilinear path area front end
// Tracks position and turns, forms corner vertices and queues cross jobs.
// ----------------------------------------------------------------------------
module rpa_front
   import rpa_pkg::*;
#(
   parameter int COORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  dir_type               in_dir_a,
   input  logic [LEN_W-1:0]      in_meters_a,
   input  dir_type               in_dir_b,
   input  logic [LEN_W-1:0]      in_meters_b,
   input  logic                  in_last,
   input  logic                  job_full,
   output logic                  job_push,
   output job_ctl_type           job_ctl,
   output logic [COORD_BITS-1:0] job_ax,
   output logic [COORD_BITS-1:0] job_ay,
   output logic [COORD_BITS-1:0] job_bx,
   output logic [COORD_BITS-1:0] job_by
);

   localparam int EW = COORD_BITS + LEN_W + 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef enum logic [2:0] {
      FE_RUN   = 3'b001,
      FE_TURN  = 3'b010,
      FE_CLOSE = 3'b100
   } fe_state_type;

   fe_state_type state_ff, state_in;
   logic         sel_ff, sel_in;
   coord_type    pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   dir_type      prev_dir_ff, prev_dir_in, first_dir_ff, first_dir_in;
   logic         have_prev_ff, have_prev_in;
   logic         have_vertex_ff, have_vertex_in;
   logic         covf_ff, covf_in;
   coord_type    first_vx_ff, first_vx_in, first_vy_ff, first_vy_in;
   coord_type    recent_vx_ff, recent_vx_in, recent_vy_ff, recent_vy_in;
   coord_type    pend_rax_ff, pend_rax_in, pend_ray_ff, pend_ray_in;
   coord_type    pend_rbx_ff, pend_rbx_in, pend_rby_ff, pend_rby_in;
   coord_type    pend_fx_ff, pend_fx_in, pend_fy_ff, pend_fy_in;
   logic         pend_term_ff, pend_term_in;
   logic         pend_covf_ff, pend_covf_in;

   dir_type               dir_sel;
   logic [LEN_W-1:0]      len_sel;
   logic                  accept;
   logic                  v1_hit, v2_hit;
   dir_type               c1, c2;
   logic [COORD_BITS:0]   v1x_r, v1y_r, v2x_r, v2y_r;
   coord_type             v1x, v1y, v2x, v2y;
   logic                  v1_ovf, v2_ovf;
   logic signed [EW-1:0]  len_ext, ext_x, ext_y, mv_x, mv_y;
   coord_type             npos_x, npos_y;
   logic                  mv_ovf;
   dir_type               first_d;
   logic                  hv1, hv2;
   coord_type             fv1x, fv1y, rv1x, rv1y, fv2x, fv2y, rv2x, rv2y;
   logic                  covf_mid, covf_all;

   function automatic logic is_cw(dir_type cur, dir_type nxt);
      return nxt == DIR_W'(cur + 2'd1);
   endfunction

   function automatic logic off_x(dir_type c);
      return (c == DIR_RIGHT) || (c == DIR_DOWN);
   endfunction

   function automatic logic off_y(dir_type c);
      return (c == DIR_DOWN) || (c == DIR_LEFT);
   endfunction

   // add a 0/1 corner offset, top bit flags a wrap
   function automatic logic [COORD_BITS:0] bump(coord_type v, logic inc);
      logic [COORD_BITS:0] s;
      s = {v[COORD_BITS-1], v} + {{COORD_BITS{1'b0}}, inc};
      return {s[COORD_BITS] ^ s[COORD_BITS-1], s[COORD_BITS-1:0]};
   endfunction

   assign dir_sel  = sel_ff ? in_dir_b : in_dir_a;
   assign len_sel  = sel_ff ? in_meters_b : in_meters_a;
   assign in_ready = (state_ff == FE_RUN) && !job_full;
   assign accept   = in_valid && in_ready;

   // corner with the previous move, at the position before this move
   always_comb begin
      v1_hit = have_prev_ff && (is_cw(prev_dir_ff, dir_sel) || is_cw(dir_sel, prev_dir_ff));
      c1     = is_cw(prev_dir_ff, dir_sel) ? prev_dir_ff : dir_sel;
      v1x_r  = bump(pos_x_ff, off_x(c1));
      v1y_r  = bump(pos_y_ff, off_y(c1));
      v1x    = v1x_r[COORD_BITS-1:0];
      v1y    = v1y_r[COORD_BITS-1:0];
      v1_ovf = v1_hit && (v1x_r[COORD_BITS] || v1y_r[COORD_BITS]);
   end

   // position update
   always_comb begin
      len_ext = EW'(len_sel);
      ext_x   = EW'(pos_x_ff);
      ext_y   = EW'(pos_y_ff);
      mv_x    = ext_x;
      mv_y    = ext_y;
      case (dir_sel)
         DIR_RIGHT: mv_x = ext_x + len_ext;
         DIR_DOWN:  mv_y = ext_y + len_ext;
         DIR_LEFT:  mv_x = ext_x - len_ext;
         default:   mv_y = ext_y - len_ext;
      endcase
      npos_x = mv_x[COORD_BITS-1:0];
      npos_y = mv_y[COORD_BITS-1:0];
      mv_ovf = (mv_x[EW-1:COORD_BITS-1] != {(EW-COORD_BITS+1){mv_x[EW-1]}})
            || (mv_y[EW-1:COORD_BITS-1] != {(EW-COORD_BITS+1){mv_y[EW-1]}});
   end

   // closing corner against the first move, at the new position
   always_comb begin
      first_d = have_prev_ff ? first_dir_ff : dir_sel;
      v2_hit  = is_cw(dir_sel, first_d) || is_cw(first_d, dir_sel);
      c2      = is_cw(dir_sel, first_d) ? dir_sel : first_d;
      v2x_r   = bump(npos_x, off_x(c2));
      v2y_r   = bump(npos_y, off_y(c2));
      v2x     = v2x_r[COORD_BITS-1:0];
      v2y     = v2y_r[COORD_BITS-1:0];
      v2_ovf  = v2_hit && (v2x_r[COORD_BITS] || v2y_r[COORD_BITS]);
   end

   always_comb begin
      hv1      = have_vertex_ff || v1_hit;
      fv1x     = (v1_hit && !have_vertex_ff) ? v1x : first_vx_ff;
      fv1y     = (v1_hit && !have_vertex_ff) ? v1y : first_vy_ff;
      rv1x     = v1_hit ? v1x : recent_vx_ff;
      rv1y     = v1_hit ? v1y : recent_vy_ff;
      hv2      = hv1 || v2_hit;
      fv2x     = (v2_hit && !hv1) ? v2x : fv1x;
      fv2y     = (v2_hit && !hv1) ? v2y : fv1y;
      rv2x     = v2_hit ? v2x : rv1x;
      rv2y     = v2_hit ? v2y : rv1y;
      covf_mid = covf_ff || v1_ovf || mv_ovf;
      covf_all = covf_mid || v2_ovf;
   end

   always_comb begin
      state_in       = state_ff;
      sel_in         = csr_wr_en ? csr_wr_data : sel_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      prev_dir_in    = prev_dir_ff;
      first_dir_in   = first_dir_ff;
      have_prev_in   = have_prev_ff;
      have_vertex_in = have_vertex_ff;
      covf_in        = covf_ff;
      first_vx_in    = first_vx_ff;
      first_vy_in    = first_vy_ff;
      recent_vx_in   = recent_vx_ff;
      recent_vy_in   = recent_vy_ff;
      pend_rax_in    = pend_rax_ff;
      pend_ray_in    = pend_ray_ff;
      pend_rbx_in    = pend_rbx_ff;
      pend_rby_in    = pend_rby_ff;
      pend_fx_in     = pend_fx_ff;
      pend_fy_in     = pend_fy_ff;
      pend_term_in   = pend_term_ff;
      pend_covf_in   = pend_covf_ff;
      job_push       = 1'b0;
      job_ctl        = '0;
      job_ax         = recent_vx_ff;
      job_ay         = recent_vy_ff;
      job_bx         = v1x;
      job_by         = v1y;
      unique case (state_ff)
         FE_RUN: begin
            job_push        = accept && v1_hit && have_vertex_ff;
            job_ctl.term_en = 1'b1;
            if (accept) begin
               if (in_last) begin
                  pos_x_in       = '0;
                  pos_y_in       = '0;
                  prev_dir_in    = DIR_RIGHT;
                  first_dir_in   = DIR_RIGHT;
                  have_prev_in   = 1'b0;
                  have_vertex_in = 1'b0;
                  covf_in        = 1'b0;
                  pend_rax_in    = rv1x;
                  pend_ray_in    = rv1y;
                  pend_rbx_in    = rv2x;
                  pend_rby_in    = rv2y;
                  pend_fx_in     = fv2x;
                  pend_fy_in     = fv2y;
                  pend_term_in   = hv2;
                  pend_covf_in   = covf_all;
                  state_in       = (v2_hit && hv1) ? FE_TURN : FE_CLOSE;
               end else begin
                  pos_x_in       = npos_x;
                  pos_y_in       = npos_y;
                  prev_dir_in    = dir_sel;
                  first_dir_in   = first_d;
                  have_prev_in   = 1'b1;
                  have_vertex_in = hv1;
                  covf_in        = covf_mid;
                  first_vx_in    = fv1x;
                  first_vy_in    = fv1y;
                  recent_vx_in   = rv1x;
                  recent_vy_in   = rv1y;
               end
            end
         end
         FE_TURN: begin
            job_push        = !job_full;
            job_ctl.term_en = 1'b1;
            job_ax          = pend_rax_ff;
            job_ay          = pend_ray_ff;
            job_bx          = pend_rbx_ff;
            job_by          = pend_rby_ff;
            if (!job_full) begin
               state_in = FE_CLOSE;
            end
         end
         FE_CLOSE: begin
            job_push          = !job_full;
            job_ctl.term_en   = pend_term_ff;
            job_ctl.close     = 1'b1;
            job_ctl.coord_ovf = pend_covf_ff;
            job_ax            = pend_rbx_ff;
            job_ay            = pend_rby_ff;
            job_bx            = pend_fx_ff;
            job_by            = pend_fy_ff;
            if (!job_full) begin
               state_in = FE_RUN;
            end
         end
         default: begin
            state_in = FE_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= FE_RUN;
         sel_ff         <= 1'b0;
         pos_x_ff       <= '0;
         pos_y_ff       <= '0;
         prev_dir_ff    <= DIR_RIGHT;
         first_dir_ff   <= DIR_RIGHT;
         have_prev_ff   <= 1'b0;
         have_vertex_ff <= 1'b0;
         covf_ff        <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sel_ff         <= sel_in;
         pos_x_ff       <= pos_x_in;
         pos_y_ff       <= pos_y_in;
         prev_dir_ff    <= prev_dir_in;
         first_dir_ff   <= first_dir_in;
         have_prev_ff   <= have_prev_in;
         have_vertex_ff <= have_vertex_in;
         covf_ff        <= covf_in;
      end
   end

   always_ff @(posedge clock) begin
      first_vx_ff  <= first_vx_in;
      first_vy_ff  <= first_vy_in;
      recent_vx_ff <= recent_vx_in;
      recent_vy_ff <= recent_vy_in;
      pend_rax_ff  <= pend_rax_in;
      pend_ray_ff  <= pend_ray_in;
      pend_rbx_ff  <= pend_rbx_in;
      pend_rby_ff  <= pend_rby_in;
      pend_fx_ff   <= pend_fx_in;
      pend_fy_ff   <= pend_fy_in;
      pend_term_ff <= pend_term_in;
      pend_covf_ff <= pend_covf_in;
   end

endmodule

/* rtl/rpa_back.sv */
// ----------------------------------------------------------------------------
// Rectilinear path area back end
// Pipelined cross products, checked accumulation and the area result register.
// ----------------------------------------------------------------------------
module rpa_back
   import rpa_pkg::*;
#(
   parameter int COORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   output logic                  job_pop,
   input  job_ctl_type           job_ctl,
   input  logic [COORD_BITS-1:0] job_ax,
   input  logic [COORD_BITS-1:0] job_ay,
   input  logic [COORD_BITS-1:0] job_bx,
   input  logic [COORD_BITS-1:0] job_by,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [AREA_W-1:0]     out_area,
   output logic                  out_overflow
);

   localparam int LW = COORD_BITS / 2;
   localparam int HW = COORD_BITS - LW;
   localparam int PW = (2 * COORD_BITS > SUM_W) ? 2 * COORD_BITS : SUM_W;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic signed [2*HW-1:0]  hh;
      logic signed [LW+HW:0]   hl;
      logic signed [LW+HW:0]   lh;
      logic signed [2*LW+1:0]  ll;
   } part_type;

   // split product, each partial a product of a high or low half of a coordinate
   function automatic part_type mul_parts(coord_type x, coord_type y);
      part_type               pp;
      logic signed [HW-1:0]   x_hi, y_hi;
      logic signed [LW:0]     x_lo, y_lo;
      x_hi  = x[COORD_BITS-1:LW];
      y_hi  = y[COORD_BITS-1:LW];
      x_lo  = {1'b0, x[LW-1:0]};
      y_lo  = {1'b0, y[LW-1:0]};
      pp.hh = x_hi * y_hi;
      pp.hl = x_hi * y_lo;
      pp.lh = x_lo * y_hi;
      pp.ll = x_lo * y_lo;
      return pp;
   endfunction

   function automatic logic signed [PW-1:0] join_parts(part_type pp);
      logic signed [PW-1:0] hh, mid, ll;
      hh  = PW'(signed'(pp.hh));
      mid = PW'(signed'(pp.hl)) + PW'(signed'(pp.lh));
      ll  = PW'(signed'(pp.ll));
      return (hh <<< (2 * LW)) + (mid <<< LW) + ll;
   endfunction

   logic                     adv;

   logic                     s1_valid_ff, s1_valid_in;
   job_ctl_type              s1_ctl_ff, s1_ctl_in;
   part_type                 s1_p_ff, s1_p_in, s1_q_ff, s1_q_in;

   logic                     s2_valid_ff, s2_valid_in;
   job_ctl_type              s2_ctl_ff, s2_ctl_in;
   logic signed [PW-1:0]     s2_p_ff, s2_p_in, s2_q_ff, s2_q_in;

   logic                     s3_valid_ff, s3_valid_in;
   job_ctl_type              s3_ctl_ff, s3_ctl_in;
   logic signed [SUM_W-1:0]  s3_d_ff, s3_d_in;
   logic                     s3_bad_ff, s3_bad_in;

   logic signed [SUM_W-1:0]  acc_ff, acc_in;
   logic                     acc_ovf_ff, acc_ovf_in;
   logic                     fin_valid_ff, fin_valid_in;
   logic signed [SUM_W-1:0]  fin_sum_ff, fin_sum_in;
   logic                     fin_ovf_ff, fin_ovf_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [AREA_W-1:0]        rsp_area_ff, rsp_area_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;

   logic                     p_big, q_big, d_big, s_big;
   logic signed [SUM_W:0]    diff, sum;
   logic                     term_bad;
   logic signed [SUM_W-1:0]  new_acc;
   logic                     new_ovf;
   logic [SUM_W-1:0]         mag;

   assign adv     = !rsp_valid_ff || out_ready;
   assign job_pop = adv && job_valid;

   always_comb begin
      p_big = (s2_p_ff[PW-1:SUM_W-1] != {(PW-SUM_W+1){s2_p_ff[PW-1]}})
           || (s2_p_ff[SUM_W-1:0] == SUM_MIN);
      q_big = (s2_q_ff[PW-1:SUM_W-1] != {(PW-SUM_W+1){s2_q_ff[PW-1]}})
           || (s2_q_ff[SUM_W-1:0] == SUM_MIN);
      diff  = (SUM_W+1)'(signed'(s2_p_ff[SUM_W-1:0]))
            - (SUM_W+1)'(signed'(s2_q_ff[SUM_W-1:0]));
      d_big = diff[SUM_W] != diff[SUM_W-1];

      sum      = (SUM_W+1)'(acc_ff) + (SUM_W+1)'(s3_d_ff);
      s_big    = sum[SUM_W] != sum[SUM_W-1];
      term_bad = s3_ctl_ff.term_en && (s3_bad_ff || s_big);
      new_acc  = (s3_ctl_ff.term_en && !term_bad) ? sum[SUM_W-1:0] : acc_ff;
      new_ovf  = acc_ovf_ff || term_bad;

      mag = fin_sum_ff[SUM_W-1] ? (~fin_sum_ff + 1'b1) : fin_sum_ff;
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_ctl_in    = s1_ctl_ff;
      s1_p_in      = s1_p_ff;
      s1_q_in      = s1_q_ff;
      s2_valid_in  = s2_valid_ff;
      s2_ctl_in    = s2_ctl_ff;
      s2_p_in      = s2_p_ff;
      s2_q_in      = s2_q_ff;
      s3_valid_in  = s3_valid_ff;
      s3_ctl_in    = s3_ctl_ff;
      s3_d_in      = s3_d_ff;
      s3_bad_in    = s3_bad_ff;
      acc_in       = acc_ff;
      acc_ovf_in   = acc_ovf_ff;
      fin_valid_in = fin_valid_ff;
      fin_sum_in   = fin_sum_ff;
      fin_ovf_in   = fin_ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_area_in  = rsp_area_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (adv) begin
         s1_valid_in  = job_valid;
         s1_ctl_in    = job_ctl;
         s1_p_in      = mul_parts(job_ax, job_by);
         s1_q_in      = mul_parts(job_bx, job_ay);

         s2_valid_in  = s1_valid_ff;
         s2_ctl_in    = s1_ctl_ff;
         s2_p_in      = join_parts(s1_p_ff);
         s2_q_in      = join_parts(s1_q_ff);

         s3_valid_in  = s2_valid_ff;
         s3_ctl_in    = s2_ctl_ff;
         s3_d_in      = diff[SUM_W-1:0];
         s3_bad_in    = p_big || q_big || d_big;

         fin_valid_in = s3_valid_ff && s3_ctl_ff.close;
         fin_sum_in   = new_acc;
         fin_ovf_in   = new_ovf || s3_ctl_ff.coord_ovf;
         if (s3_valid_ff) begin
            if (s3_ctl_ff.close) begin
               acc_in     = '0;
               acc_ovf_in = 1'b0;
            end else begin
               acc_in     = new_acc;
               acc_ovf_in = new_ovf;
            end
         end

         rsp_valid_in = fin_valid_ff;
         rsp_area_in  = fin_ovf_ff ? '0 : mag[SUM_W-1:1];
         rsp_ovf_in   = fin_ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         acc_ovf_ff   <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         acc_ovf_ff   <= acc_ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctl_ff   <= s1_ctl_in;
      s1_p_ff     <= s1_p_in;
      s1_q_ff     <= s1_q_in;
      s2_ctl_ff   <= s2_ctl_in;
      s2_p_ff     <= s2_p_in;
      s2_q_ff     <= s2_q_in;
      s3_ctl_ff   <= s3_ctl_in;
      s3_d_ff     <= s3_d_in;
      s3_bad_ff   <= s3_bad_in;
      fin_sum_ff  <= fin_sum_in;
      fin_ovf_ff  <= fin_ovf_in;
      rsp_area_ff <= rsp_area_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign out_valid    = rsp_valid_ff;
   assign out_area     = rsp_area_ff;
   assign out_overflow = rsp_ovf_ff;

endmodule

/* rtl/rpa_checker.sv */
// ----------------------------------------------------------------------------
// Rectilinear path area checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "rectilinear_path_area_assert.svh"

module rpa_checker
   import rpa_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // stalled result holds
   `RPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // overflowed path reports zero area
   `RPA_ASSERT_NOW(a_ovf_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[AREA_W-1:0] == '0)

   // closing a path takes the input away in the cycle after the last move is accepted
   `RPA_ASSERT_NEXT(a_last_busy, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready)

   // no result right after reset
   `RPA_ASSERT_AFTER_RESET(a_reset_quiet, clock, reset, !rsp_tvalid)

endmodule

bind rectilinear_path_area rpa_checker u_rpa_checker (.*);
